// File: src/rpd_pkg.sv
// Shared types, byte codes and the CRC-16/XMODEM byte update for the record
// packet deframer. No dependencies; every other file of the block imports it.
package rpd_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int MAX_RECORDS_DEF  = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0]  BYTE_CMD = 8'h05;
    localparam logic [7:0]  BYTE_ACK = 8'h06;
    localparam logic [7:0]  BYTE_NAK = 8'h15;
    localparam logic [7:0]  BYTE_END = 8'h04;
    localparam logic [7:0]  BYTE_CRC = 8'h1a;
    localparam logic [7:0]  BYTE_SEP = 8'h1e;
    localparam logic [15:0] CRC_SEED = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_SEP   = 2'd1,
        KIND_END   = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CLS_START = 3'd0,
        CLS_END   = 3'd1,
        CLS_CRC   = 3'd2,
        CLS_SEP   = 3'd3,
        CLS_OTHER = 3'd4
    } t_cls;

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
        logic       is_cmd;
        logic       hex_ok;
        logic [3:0] hex_digit;
    } t_item;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/record_packet_deframer_crc16_top.sv
// Top level of the record packet deframer with CRC-16/XMODEM check.
// Instantiates rpd_front, rpd_queue and rpd_back; uses rpd_pkg.
//
// Usage: received bytes enter on the input channel (i_in_valid, o_in_ready,
// i_in_byte), one word per handshake. Outside a packet, bytes are dropped
// until a start byte (0x05 command, 0x06 or 0x15 response) opens one. Inside
// a packet, each payload byte leaves as a data word tagged with its record
// index, each 0x1e as a separator word, and 0x04 as a packet end word that
// reports the record count and the CRC check. Bytes of the hex CRC field
// after 0x1a give no word. Overruns and restarts give an aborted word.
// Results leave on the output channel (o_out_valid, i_out_ready, o_kind ...).
//
// Throughput: an accepted byte is registered in the queue, and its result
// word is registered in the output register when the back end pops it. One
// byte per cycle is sustained while the receiver takes the words; the back
// end's byte-wide CRC update and packet state logic are combinational.
// Reset (synchronous, active low) closes any packet and empties the queue
// and the output register. When the receiver stalls, the output register
// holds its word, the two-entry queue takes up to two more bytes, and then
// o_in_ready drops until the receiver takes the pending word.
module record_packet_deframer_crc16_top #(
    parameter int BUFFER_BYTES = rpd_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_RECORDS  = rpd_pkg::MAX_RECORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [3:0] o_record_index,
    output logic       o_is_response,
    output logic       o_crc_present,
    output logic       o_crc_ok,
    output logic [4:0] o_record_count
);
    import rpd_pkg::*;

    // Words move from the classifier into the queue whenever it has room.
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_valid;
    t_item front_item;
    t_item queue_item;

    rpd_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_queue_full (queue_full),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_item       (front_item)
    );

    rpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    // The back end pops a word whenever its output register is empty or
    // being emptied in the same cycle.
    rpd_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (queue_valid),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_record_index (o_record_index),
        .o_is_response  (o_is_response),
        .o_crc_present  (o_crc_present),
        .o_crc_ok       (o_crc_ok),
        .o_record_count (o_record_count)
    );

endmodule

// File: src/rpd_front.sv
// Front end of the deframer: takes input bytes, classifies them and decodes
// hex digits, then pushes the tagged word into the queue. Uses rpd_pkg.
module rpd_front (
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_queue_full,
    output logic          o_in_ready,
    output logic          o_push,
    output rpd_pkg::t_item o_item
);
    import rpd_pkg::*;

    t_cls       cls;
    logic       hex_ok;
    logic [3:0] hex_digit;
    logic [7:0] off;

    always_comb begin
        case (i_in_byte)
            BYTE_CMD, BYTE_ACK, BYTE_NAK: cls = CLS_START;
            BYTE_END:                     cls = CLS_END;
            BYTE_CRC:                     cls = CLS_CRC;
            BYTE_SEP:                     cls = CLS_SEP;
            default:                      cls = CLS_OTHER;
        endcase
    end

    // Digits 0-9, a-f and A-F are accepted by the hex field reader.
    always_comb begin
        hex_ok = 1'b1;
        off    = 8'h00;
        case (i_in_byte) inside
            [8'h30:8'h39]: off = i_in_byte - 8'h30;
            [8'h61:8'h66]: off = i_in_byte - 8'h57;
            [8'h41:8'h46]: off = i_in_byte - 8'h37;
            default:       hex_ok = 1'b0;
        endcase
        hex_digit = off[3:0];
    end

    assign o_in_ready       = !i_queue_full;
    assign o_push           = i_in_valid && !i_queue_full;
    assign o_item.data      = i_in_byte;
    assign o_item.cls       = cls;
    assign o_item.is_cmd    = (i_in_byte == BYTE_CMD);
    assign o_item.hex_ok    = hex_ok;
    assign o_item.hex_digit = hex_digit;

endmodule

// File: src/rpd_queue.sv
// Short queue of classified words between the front end and the back end.
// Uses rpd_pkg for the word type and depth.
module rpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpd_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rpd_pkg::t_item o_item
);
    import rpd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

endmodule

// File: src/rpd_back.sv
// Back end of the deframer: packet state, CRC accumulation, hex field reader
// and the registered result word. Uses rpd_pkg.
module rpd_back #(
    parameter int BUFFER_BYTES = rpd_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_RECORDS  = rpd_pkg::MAX_RECORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  rpd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_data_byte,
    output logic [3:0]     o_record_index,
    output logic           o_is_response,
    output logic           o_crc_present,
    output logic           o_crc_ok,
    output logic [4:0]     o_record_count
);
    import rpd_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int REC_W  = $clog2(MAX_RECORDS + 1);

    logic              r_in_packet, n_in_packet;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_resp, n_resp;
    logic [REC_W-1:0]  r_records, n_records;
    logic [15:0]       r_crc, n_crc;
    logic [15:0]       r_covered, n_covered;
    logic              r_crc_seen, n_crc_seen;
    logic [15:0]       r_hex, n_hex;
    logic              r_hex_stop, n_hex_stop;

    logic              r_out_valid;
    t_kind             r_kind, n_kind;
    logic [7:0]        r_data, n_data;
    logic [3:0]        r_index, n_index;
    logic              r_out_resp, n_out_resp;
    logic              r_present, n_present;
    logic              r_match, n_match;
    logic [4:0]        r_count, n_count;
    logic              emit;

    logic              full;
    logic [7:0]        store_val;
    logic [15:0]       crc_next;
    logic [REC_W-1:0]  idx_cur;

    assign o_pop     = i_item_valid && (!r_out_valid || i_out_ready);
    assign full      = (r_fill >= FILL_W'(BUFFER_BYTES));
    assign store_val = (i_item.cls == CLS_CRC) ? 8'h00 : i_item.data;
    assign crc_next  = crc16_update(r_crc, store_val);
    assign idx_cur   = (r_records != '0) ? r_records - 1'b1 : '0;

    always_comb begin
        n_in_packet = r_in_packet;
        n_fill      = r_fill;
        n_resp      = r_resp;
        n_records   = r_records;
        n_crc       = r_crc;
        n_covered   = r_covered;
        n_crc_seen  = r_crc_seen;
        n_hex       = r_hex;
        n_hex_stop  = r_hex_stop;
        emit        = 1'b0;
        n_kind      = KIND_ABORT;
        n_data      = 8'h00;
        n_index     = 4'(idx_cur);
        n_out_resp  = r_resp;
        n_present   = 1'b0;
        n_match     = 1'b0;
        n_count     = 5'd0;

        // Closing a packet clears everything but the response flag.
        if (i_item.cls == CLS_START) begin
            emit        = r_in_packet;
            n_in_packet = 1'b1;
            n_resp      = !i_item.is_cmd;
            n_records   = REC_W'(1);
            n_fill      = '0;
            n_crc       = CRC_SEED;
            n_covered   = CRC_SEED;
            n_crc_seen  = 1'b0;
            n_hex       = 16'h0000;
            n_hex_stop  = 1'b0;
        end else if (r_in_packet) begin
            case (i_item.cls)
                CLS_END: begin
                    emit      = 1'b1;
                    n_kind    = KIND_END;
                    n_present = r_crc_seen;
                    n_match   = r_crc_seen ? (r_covered == r_hex) : 1'b1;
                    n_count   = 5'(r_records);
                end
                CLS_CRC: begin
                    if (full) begin
                        emit = 1'b1;
                    end else begin
                        n_covered  = r_crc;
                        n_crc      = crc_next;
                        n_fill     = r_fill + 1'b1;
                        n_crc_seen = 1'b1;
                        n_hex      = 16'h0000;
                        n_hex_stop = 1'b0;
                    end
                end
                CLS_SEP: begin
                    emit = 1'b1;
                    if (!(r_records >= REC_W'(MAX_RECORDS) || full)) begin
                        n_kind    = KIND_SEP;
                        n_index   = 4'(r_records);
                        n_records = r_records + 1'b1;
                        n_crc     = crc_next;
                        n_fill    = r_fill + 1'b1;
                        if (r_crc_seen) begin
                            n_hex_stop = 1'b1;
                        end
                    end
                end
                default: begin
                    if (full) begin
                        emit = 1'b1;
                    end else begin
                        n_crc  = crc_next;
                        n_fill = r_fill + 1'b1;
                        if (r_crc_seen) begin
                            if (!r_hex_stop) begin
                                if (i_item.hex_ok) begin
                                    n_hex = {r_hex[11:0], i_item.hex_digit};
                                end else begin
                                    n_hex_stop = 1'b1;
                                end
                            end
                        end else begin
                            emit   = 1'b1;
                            n_kind = KIND_DATA;
                            n_data = i_item.data;
                        end
                    end
                end
            endcase

            // Packet end and every abort close the packet.
            if (emit && (n_kind == KIND_END || n_kind == KIND_ABORT)) begin
                n_in_packet = 1'b0;
                n_fill      = '0;
                n_records   = '0;
                n_crc       = CRC_SEED;
                n_covered   = CRC_SEED;
                n_crc_seen  = 1'b0;
                n_hex       = 16'h0000;
                n_hex_stop  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_fill      <= '0;
            r_resp      <= 1'b0;
            r_records   <= '0;
            r_crc       <= CRC_SEED;
            r_covered   <= CRC_SEED;
            r_crc_seen  <= 1'b0;
            r_hex       <= 16'h0000;
            r_hex_stop  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_packet <= n_in_packet;
                r_fill      <= n_fill;
                r_resp      <= n_resp;
                r_records   <= n_records;
                r_crc       <= n_crc;
                r_covered   <= n_covered;
                r_crc_seen  <= n_crc_seen;
                r_hex       <= n_hex;
                r_hex_stop  <= n_hex_stop;
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind     <= n_kind;
            r_data     <= n_data;
            r_index    <= n_index;
            r_out_resp <= n_out_resp;
            r_present  <= n_present;
            r_match    <= n_match;
            r_count    <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data;
    assign o_record_index = r_index;
    assign o_is_response  = r_out_resp;
    assign o_crc_present  = r_present;
    assign o_crc_ok       = r_match;
    assign o_record_count = r_count;

endmodule
